FILE: rtl/mwm_pkg.sv
// shared types and constants of the mecanum wheel mixer with speed normalization
// no dependencies; used by mwm_div_step and the core top level
`default_nettype none

package mwm_pkg;

  parameter int FRACTION_BITS_DEF = 12;   // default fraction bits of all speeds
  parameter int NUM_WHEELS        = 4;
  parameter int SPEED_W           = 16;   // wheel and chassis speed field width
  parameter int CFG_W             = 15;   // gain and limit register width
  parameter int QUO_W             = 16;   // quotient bits of 2*m*lim/max
  parameter int ADDR_W            = 3;    // two 32-bit registers at 0 and 4
  parameter int DATA_W            = 32;

  parameter logic [CFG_W-1:0] GAIN_RESET  = 15'd4096;
  parameter logic [CFG_W-1:0] LIMIT_RESET = 15'd16384;

  // per-item sideband that rides along the divider
  typedef struct packed {
    logic                             scale;  // max magnitude above limit
    logic [NUM_WHEELS-1:0]            neg;    // wheel sum was negative
    logic [NUM_WHEELS-1:0][CFG_W-1:0] rnd;    // unscaled rounded magnitude
  } mwm_side_t;

endpackage

`default_nettype wire

FILE: rtl/mwm_div_step.sv
// one registered restoring-division step for all four wheel lanes
// depends on mwm_pkg for lane count, quotient width and the sideband struct
`default_nettype none

module mwm_div_step #(
  parameter int MAG_W = 33
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                en_i,
  input  wire logic [MAG_W-1:0]                                    den_i,
  input  wire logic [mwm_pkg::NUM_WHEELS-1:0][MAG_W-1:0]           rem_i,
  input  wire logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::QUO_W-1:0]  low_i,
  input  wire logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::QUO_W-1:0]  quo_i,
  input  wire mwm_pkg::mwm_side_t                                  side_i,
  output logic      [MAG_W-1:0]                                    den_o,
  output logic      [mwm_pkg::NUM_WHEELS-1:0][MAG_W-1:0]           rem_o,
  output logic      [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::QUO_W-1:0]  low_o,
  output logic      [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::QUO_W-1:0]  quo_o,
  output mwm_pkg::mwm_side_t                                       side_o
);

  localparam int NW = mwm_pkg::NUM_WHEELS;
  localparam int QW = mwm_pkg::QUO_W;

  logic [NW-1:0][MAG_W-1:0] rem_d;
  logic [NW-1:0][QW-1:0]    low_d;
  logic [NW-1:0][QW-1:0]    quo_d;
  logic [NW-1:0][MAG_W-1:0] rem_q;
  logic [NW-1:0][QW-1:0]    low_q;
  logic [NW-1:0][QW-1:0]    quo_q;
  logic [MAG_W-1:0]         den_q;
  mwm_pkg::mwm_side_t       side_q;

  always_comb begin
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           ge;
    for (int l = 0; l < NW; l++) begin
      // bring down the next numerator bit, subtract when it fits
      trial    = {rem_i[l], low_i[l][QW-1]};
      diff     = trial - {1'b0, den_i};
      ge       = (trial >= {1'b0, den_i});
      rem_d[l] = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      quo_d[l] = {quo_i[l][QW-2:0], ge};
      low_d[l] = {low_i[l][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      low_q  <= low_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign rem_o  = rem_q;
  assign low_o  = low_q;
  assign quo_o  = quo_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

FILE: rtl/mecanum_wheel_mixer_desaturate_core.sv
// top level of the mecanum wheel mixer with wheel speed normalization
// depends on mwm_pkg and mwm_div_step
`default_nettype none

// Mixes a chassis command (forward, sideways, turn rate; signed, FRACTION_BITS
// fraction bits) into four mecanum wheel speeds. The wide exact sums are
// checked against wheel_speed_limit; when the largest magnitude is above it,
// every wheel is scaled by limit/max with round-half-away-from-zero and
// was_scaled is set, otherwise each wheel is rounded to FRACTION_BITS. The
// block takes one command per clock unless a stall fills every stage; it has one stage
// for the turn-rate multiply, one for the wheel sums, one for the max search
// and the magnitude times limit products, one for the divider setup, sixteen
// restoring divider stages that each produce one quotient bit per wheel, and
// the output register. Every stage holds its own valid bit and moves on when
// the stage after it is empty or moving, so bubbles are squeezed out and a
// new command is taken while a finished result still waits on a stall.
// Registers sit on an APB-style port: center_gain at 0x0, wheel_speed_limit
// at 0x4; write them only while the pipeline is empty.

module mecanum_wheel_mixer_desaturate_core #(
  parameter int FRACTION_BITS = mwm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // apb-style register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mwm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mwm_pkg::DATA_W-1:0]  pwdata,
  output logic      [mwm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  // command channel
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic signed [15:0]          forward_speed_i,
  input  wire logic signed [15:0]          sideways_speed_i,
  input  wire logic signed [15:0]          turn_rate_i,
  // wheel speed channel
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic signed [15:0]               wheel_0_speed_o,
  output logic signed [15:0]               wheel_1_speed_o,
  output logic signed [15:0]               wheel_2_speed_o,
  output logic signed [15:0]               wheel_3_speed_o,
  output logic                             was_scaled_o
);

  localparam int NW   = mwm_pkg::NUM_WHEELS;
  localparam int SW   = mwm_pkg::SPEED_W;
  localparam int CW   = mwm_pkg::CFG_W;
  localparam int QW   = mwm_pkg::QUO_W;
  localparam int PW   = 2 * SW;                                  // gain times turn rate
  // signed width of the wide wheel sums, magnitude width, product width
  localparam int WS   = ((FRACTION_BITS + SW) > (PW - 1) ? (FRACTION_BITS + SW) : (PW - 1)) + 2;
  localparam int WM   = WS - 1;
  localparam int WP   = WM + CW;
  localparam int NDIV = QW;
  localparam int NS   = NDIV + 5;                                // total register stages

  typedef enum logic [0:0] {
    REG_CENTER_GAIN = 1'b0,
    REG_WHEEL_LIMIT = 1'b1
  } mwm_reg_e;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0] gain_q;
  logic [CW-1:0] limit_q;
  logic          cfg_wr;
  mwm_reg_e      cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = mwm_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= mwm_pkg::GAIN_RESET;
      limit_q <= mwm_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_CENTER_GAIN: gain_q  <= pwdata[CW-1:0];
        REG_WHEEL_LIMIT: limit_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_CENTER_GAIN: prdata = mwm_pkg::DATA_W'(gain_q);
      REG_WHEEL_LIMIT: prdata = mwm_pkg::DATA_W'(limit_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? valid_i : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NS-1];

  // ---------------------------------------------------------------------------
  // stage 0: capture the command, gain times turn rate
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] vx_q;
  logic signed [SW-1:0] vy_q;
  logic signed [PW-1:0] rot_q;
  logic signed [PW-1:0] rot_d;

  assign rot_d = PW'(signed'({1'b0, gain_q})) * PW'(turn_rate_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vx_q  <= forward_speed_i;
      vy_q  <= sideways_speed_i;
      rot_q <= rot_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: exact wide wheel sums, split into sign and magnitude
  // ---------------------------------------------------------------------------
  logic signed [WS-1:0]  vx_e;
  logic signed [WS-1:0]  vy_e;
  logic signed [WS-1:0]  rot_e;
  logic signed [WS-1:0]  wsum [NW];
  logic [NW-1:0][WM-1:0] mag_d;
  logic [NW-1:0]         neg_d;
  logic [NW-1:0][WM-1:0] mag_q;
  logic [NW-1:0]         neg1_q;

  always_comb begin
    vx_e  = WS'(vx_q) <<< FRACTION_BITS;
    vy_e  = WS'(vy_q) <<< FRACTION_BITS;
    rot_e = WS'(rot_q);
    // mecanum mix, rotation enters every wheel with the same sign
    wsum[0] = -vx_e - vy_e - rot_e;
    wsum[1] =  vx_e - vy_e - rot_e;
    wsum[2] =  vx_e + vy_e - rot_e;
    wsum[3] = -vx_e + vy_e - rot_e;
    for (int l = 0; l < NW; l++) begin
      neg_d[l] = wsum[l][WS-1];
      mag_d[l] = neg_d[l] ? WM'(-wsum[l]) : WM'(wsum[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mag_q  <= mag_d;
      neg1_q <= neg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: largest magnitude, magnitude times limit, unscaled rounding
  // ---------------------------------------------------------------------------
  logic [WM-1:0]         mx_a;
  logic [WM-1:0]         mx_b;
  logic [WM-1:0]         mx_d;
  logic [NW-1:0][WP-1:0] prod_d;
  logic [NW-1:0][CW-1:0] rnd_d;
  logic [WM-1:0]         max_q;
  logic [NW-1:0][WP-1:0] prod_q;
  logic [NW-1:0][CW-1:0] rnd_q;
  logic [NW-1:0]         neg2_q;

  always_comb begin
    logic [WM:0] rsum;
    logic [WM:0] rsh;
    mx_a = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    mx_b = (mag_q[2] > mag_q[3]) ? mag_q[2] : mag_q[3];
    mx_d = (mx_a > mx_b) ? mx_a : mx_b;
    for (int l = 0; l < NW; l++) begin
      prod_d[l] = WP'(mag_q[l]) * WP'(limit_q);
      // round half away from zero on the magnitude
      rsum      = (WM + 1)'(mag_q[l]) + ((WM + 1)'(1) << (FRACTION_BITS - 1));
      rsh       = rsum >> FRACTION_BITS;
      rnd_d[l]  = rsh[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      max_q  <= mx_d;
      prod_q <= prod_d;
      rnd_q  <= rnd_d;
      neg2_q <= neg1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: scale decision and divider setup
  // quotient a = floor(2*m*lim / max) has 16 bits, so the top of 2*m*lim
  // (that is m*lim >> 15) already sits below max and seeds the remainder
  // ---------------------------------------------------------------------------
  logic [WM-1:0]         den_s  [NDIV+1];
  logic [NW-1:0][WM-1:0] rem_s  [NDIV+1];
  logic [NW-1:0][QW-1:0] low_s  [NDIV+1];
  logic [NW-1:0][QW-1:0] quo_s  [NDIV+1];
  mwm_pkg::mwm_side_t    side_s [NDIV+1];

  mwm_pkg::mwm_side_t    side_d;
  logic [NW-1:0][WM-1:0] rem_init;
  logic [NW-1:0][QW-1:0] low_init;

  always_comb begin
    side_d.scale = max_q > (WM'(limit_q) << FRACTION_BITS);
    side_d.neg   = neg2_q;
    side_d.rnd   = rnd_q;
    for (int l = 0; l < NW; l++) begin
      rem_init[l] = WM'(prod_q[l] >> (QW - 1));
      low_init[l] = {prod_q[l][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      den_s[0]  <= max_q;
      rem_s[0]  <= rem_init;
      low_s[0]  <= low_init;
      quo_s[0]  <= '0;
      side_s[0] <= side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 4 .. 19: one quotient bit per stage
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    mwm_div_step #(
      .MAG_W (WM)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (en[4 + j]),
      .den_i  (den_s[j]),
      .rem_i  (rem_s[j]),
      .low_i  (low_s[j]),
      .quo_i  (quo_s[j]),
      .side_i (side_s[j]),
      .den_o  (den_s[j+1]),
      .rem_o  (rem_s[j+1]),
      .low_o  (low_s[j+1]),
      .quo_o  (quo_s[j+1]),
      .side_o (side_s[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // output stage: halve with rounding, pick path, restore sign
  // floor((a + 1) / 2) equals round-half-up of m*lim/max
  // ---------------------------------------------------------------------------
  logic [NW-1:0][SW-1:0] wheel_d;
  logic [NW-1:0][SW-1:0] wheel_q;
  logic                  scaled_q;

  always_comb begin
    logic [QW:0]   qsum;
    logic [CW-1:0] mag_sel;
    for (int l = 0; l < NW; l++) begin
      qsum       = (QW + 1)'(quo_s[NDIV][l]) + (QW + 1)'(1);
      mag_sel    = side_s[NDIV].scale ? qsum[CW:1] : side_s[NDIV].rnd[l];
      wheel_d[l] = side_s[NDIV].neg[l] ? -{1'b0, mag_sel} : {1'b0, mag_sel};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      wheel_q  <= wheel_d;
      scaled_q <= side_s[NDIV].scale;
    end
  end

  assign wheel_0_speed_o = wheel_q[0];
  assign wheel_1_speed_o = wheel_q[1];
  assign wheel_2_speed_o = wheel_q[2];
  assign wheel_3_speed_o = wheel_q[3];
  assign was_scaled_o    = scaled_q;

`ifndef NO_ASSERTIONS
  // input is only held off when every stage is occupied
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q))
    else $error("input stalled while the pipeline has a bubble");

  // a stage that could not move keeps its item
  a_held_stage_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|(v_q & ~en)) |=> ((v_q & $past(v_q & ~en)) == $past(v_q & ~en)))
    else $error("pipeline stage dropped a held item");

  // a scaled item always divides by a nonzero maximum
  a_scale_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-2] && side_s[NDIV].scale) |-> (den_s[NDIV] != '0))
    else $error("scaling with a zero maximum magnitude");
`endif

endmodule

`default_nettype wire
